### sv/rrii_pkg.sv
package rrii_pkg;

    localparam int TABLE_DEPTH_DEF = 32;
    localparam int NUM_W = 9;
    localparam int MASK_W = 32;
    localparam int ROUND_W = 32;

    localparam logic [1:0] ACT_ENABLE  = 2'd0;
    localparam logic [1:0] ACT_DISABLE = 2'd1;
    localparam logic [1:0] ACT_FIRE    = 2'd2;

    localparam logic [2:0] STAT_REENABLED = 3'd0;
    localparam logic [2:0] STAT_INSERTED  = 3'd1;
    localparam logic [2:0] STAT_FULL      = 3'd2;
    localparam logic [2:0] STAT_NOTFOUND  = 3'd3;
    localparam logic [2:0] STAT_DISABLED  = 3'd4;
    localparam logic [2:0] STAT_FIRED     = 3'd5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_PICK,
        ST_APPLY
    } rrii_state_t;

    // per-step commands broadcast to every cell
    typedef struct packed {
        logic look;
        logic pick;
        logic set_en;
        logic clr_en;
        logic append;
    } rrii_ctrl_t;

endpackage

### sv/round_robin_interrupt_injector_unit.sv
// channel  | handshake            | payload
// ---------+----------------------+-------------------------------------------
// request  | start / busy         | action, irq_number
// result   | done (one cycle)     | status, fired, fired_number, rounds
// config   | cfg_valid/cfg_ready  | cfg_data (hang_mask)
//
// every request passes through accept, compare in all cells, round-robin
// grant along the cell chain, then update; the result strobe comes on the
// cycle after the update, when busy is already low again.
// the grant search is one pass through the row of cells, so the latency does
// not depend on the table depth. reset empties the table at once.
// the receiver cannot stall; config is always ready.
module round_robin_interrupt_injector_unit #(
    parameter int TABLE_DEPTH = rrii_pkg::TABLE_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    action,
    input  logic [rrii_pkg::NUM_W-1:0]    irq_number,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rrii_pkg::MASK_W-1:0]   cfg_data,
    output logic                          done,
    output logic [2:0]                    status,
    output logic                          fired,
    output logic [rrii_pkg::NUM_W-1:0]    fired_number,
    output logic [rrii_pkg::ROUND_W-1:0]  rounds
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    rrii_pkg::rrii_state_t state_reg, state_next;
    rrii_pkg::rrii_ctrl_t  ctrl;

    logic [rrii_pkg::MASK_W-1:0]  hang_mask_reg;
    logic [1:0]                   action_reg;
    logic [rrii_pkg::NUM_W-1:0]   number_reg;
    logic [CNT_W-1:0]             count_reg, count_next;
    logic [IDX_W-1:0]             next_slot_reg, next_slot_next;
    logic [rrii_pkg::ROUND_W-1:0] round_reg, round_next;

    logic                         done_reg;
    logic [2:0]                   status_reg, status_next;
    logic                         fired_reg, fired_next;
    logic [rrii_pkg::NUM_W-1:0]   fired_number_reg, fired_number_next;

    logic [TABLE_DEPTH:0]         taken_upper;
    logic [TABLE_DEPTH:0]         taken_all;
    logic [TABLE_DEPTH-1:0]       match_vec;
    logic [TABLE_DEPTH-1:0]       grant_vec;
    logic [TABLE_DEPTH-1:0]       hung_vec;
    logic [rrii_pkg::NUM_W-1:0]   cell_number [TABLE_DEPTH];

    logic                         found;
    logic                         any_grant;
    logic [IDX_W-1:0]             grant_idx;
    logic [rrii_pkg::NUM_W-1:0]   grant_num;
    logic                         grant_last;
    logic                         wrapped;

    assign taken_upper[0] = 1'b0;
    assign taken_all[0] = 1'b0;

    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        if (i < rrii_pkg::MASK_W)
        begin : g_mask
            assign hung_vec[i] = hang_mask_reg[i];
        end
        else
        begin : g_nomask
            assign hung_vec[i] = 1'b0;
        end

        rrii_cell #(
            .TABLE_DEPTH (TABLE_DEPTH),
            .CELL_INDEX  (i),
            .CNT_W       (CNT_W),
            .IDX_W       (IDX_W)
        ) u_cell (
            .clk             (clk),
            .rst_n           (rst_n),
            .ctrl            (ctrl),
            .req_number      (number_reg),
            .count           (count_reg),
            .next_slot       (next_slot_reg),
            .hung            (hung_vec[i]),
            .any_upper       (taken_upper[TABLE_DEPTH]),
            .taken_upper_in  (taken_upper[i]),
            .taken_all_in    (taken_all[i]),
            .taken_upper_out (taken_upper[i+1]),
            .taken_all_out   (taken_all[i+1]),
            .match           (match_vec[i]),
            .grant           (grant_vec[i]),
            .grant_number    (cell_number[i])
        );
    end

    // grant is one-hot, so the index and number fold down by or
    always_comb
    begin
        grant_idx = '0;
        grant_num = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (grant_vec[i])
            begin
                grant_idx = grant_idx | IDX_W'(i);
            end
            grant_num = grant_num | cell_number[i];
        end
    end

    assign found = |match_vec;
    assign any_grant = |grant_vec;
    assign grant_last = (CNT_W'(grant_idx) + CNT_W'(1)) == count_reg;
    assign wrapped = grant_idx < next_slot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rrii_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctrl = '0;
        count_next = count_reg;
        next_slot_next = next_slot_reg;
        round_next = round_reg;
        status_next = rrii_pkg::STAT_NOTFOUND;
        fired_next = 1'b0;
        fired_number_next = '0;
        unique case (state_reg)
            rrii_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = rrii_pkg::ST_LOOK;
                end
            end
            rrii_pkg::ST_LOOK:
            begin
                ctrl.look = 1'b1;
                state_next = rrii_pkg::ST_PICK;
            end
            rrii_pkg::ST_PICK:
            begin
                ctrl.pick = 1'b1;
                state_next = rrii_pkg::ST_APPLY;
            end
            rrii_pkg::ST_APPLY:
            begin
                state_next = rrii_pkg::ST_IDLE;
                case (action_reg)
                    rrii_pkg::ACT_ENABLE:
                    begin
                        if (found)
                        begin
                            ctrl.set_en = 1'b1;
                            status_next = rrii_pkg::STAT_REENABLED;
                        end
                        else if (count_reg == CNT_W'(TABLE_DEPTH))
                        begin
                            status_next = rrii_pkg::STAT_FULL;
                        end
                        else
                        begin
                            ctrl.append = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                            status_next = rrii_pkg::STAT_INSERTED;
                        end
                    end
                    rrii_pkg::ACT_DISABLE:
                    begin
                        if (found)
                        begin
                            ctrl.clr_en = 1'b1;
                            status_next = rrii_pkg::STAT_DISABLED;
                        end
                    end
                    rrii_pkg::ACT_FIRE:
                    begin
                        if (any_grant)
                        begin
                            status_next = rrii_pkg::STAT_FIRED;
                            fired_next = 1'b1;
                            fired_number_next = grant_num;
                            next_slot_next = grant_last ? '0 : grant_idx + IDX_W'(1);
                            if (wrapped || grant_last)
                            begin
                                round_next = round_reg + rrii_pkg::ROUND_W'(1);
                            end
                        end
                        // a full scan passes the last slot, then one more
                        else if (count_reg == '0)
                        begin
                            round_next = round_reg + rrii_pkg::ROUND_W'(1);
                        end
                        else
                        begin
                            round_next = round_reg + rrii_pkg::ROUND_W'(2);
                        end
                    end
                    default:
                    begin
                        status_next = rrii_pkg::STAT_NOTFOUND;
                    end
                endcase
            end
            default:
            begin
                state_next = rrii_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hang_mask_reg <= '0;
            count_reg <= '0;
            next_slot_reg <= '0;
            round_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                hang_mask_reg <= cfg_data;
            end
            count_reg <= count_next;
            next_slot_reg <= next_slot_next;
            round_reg <= round_next;
            done_reg <= (state_reg == rrii_pkg::ST_APPLY);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            action_reg <= action;
            number_reg <= irq_number;
        end
        if (state_reg == rrii_pkg::ST_APPLY)
        begin
            status_reg <= status_next;
            fired_reg <= fired_next;
            fired_number_reg <= fired_number_next;
        end
    end

    assign busy = (state_reg != rrii_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign done = done_reg;
    assign status = status_reg;
    assign fired = fired_reg;
    assign fired_number = fired_number_reg;
    assign rounds = round_reg;

    a_grant_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(grant_vec))
        else $error("more than one slot granted");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_pointer_range: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 && next_slot_reg == '0) || (CNT_W'(next_slot_reg) < count_reg))
        else $error("next slot pointer outside the table");

    a_fired_status: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (fired == (status == rrii_pkg::STAT_FIRED)))
        else $error("fired flag disagrees with status");

    a_done_timing: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##4 done)
        else $error("result strobe not four cycles after request");

endmodule

### sv/rrii_cell.sv
module rrii_cell #(
    parameter int TABLE_DEPTH = rrii_pkg::TABLE_DEPTH_DEF,
    parameter int CELL_INDEX = 0,
    parameter int CNT_W = $clog2(TABLE_DEPTH + 1),
    parameter int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rrii_pkg::rrii_ctrl_t          ctrl,
    input  logic [rrii_pkg::NUM_W-1:0]    req_number,
    input  logic [CNT_W-1:0]              count,
    input  logic [IDX_W-1:0]              next_slot,
    input  logic                          hung,
    input  logic                          any_upper,
    input  logic                          taken_upper_in,
    input  logic                          taken_all_in,
    output logic                          taken_upper_out,
    output logic                          taken_all_out,
    output logic                          match,
    output logic                          grant,
    output logic [rrii_pkg::NUM_W-1:0]    grant_number
);

    logic [rrii_pkg::NUM_W-1:0] number_reg;
    logic                       en_reg;
    logic                       match_reg;
    logic                       elig_reg;
    logic                       grant_reg;
    logic                       in_use;
    logic                       upper;
    logic                       req_upper;
    logic                       grant_next;

    assign in_use = CNT_W'(CELL_INDEX) < count;
    // slots at or after the pointer get first pick
    assign upper = (CNT_W'(CELL_INDEX) >= CNT_W'(next_slot));
    assign req_upper = elig_reg && upper;

    assign taken_upper_out = taken_upper_in || req_upper;
    assign taken_all_out = taken_all_in || elig_reg;
    assign grant_next = (req_upper && !taken_upper_in)
                     || (!any_upper && elig_reg && !taken_all_in);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_reg <= 1'b0;
            match_reg <= 1'b0;
            elig_reg <= 1'b0;
            grant_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.look)
            begin
                match_reg <= in_use && (number_reg == req_number);
                elig_reg <= in_use && en_reg && !hung;
            end
            if (ctrl.pick)
            begin
                grant_reg <= grant_next;
            end
            if (ctrl.set_en && match_reg)
            begin
                en_reg <= 1'b1;
            end
            if (ctrl.clr_en && match_reg)
            begin
                en_reg <= 1'b0;
            end
            if (ctrl.append && (CNT_W'(CELL_INDEX) == count))
            begin
                en_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.append && (CNT_W'(CELL_INDEX) == count))
        begin
            number_reg <= req_number;
        end
    end

    assign match = match_reg;
    assign grant = grant_reg;
    assign grant_number = grant_reg ? number_reg : '0;

endmodule

### sim/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD    = 4;
    localparam int DEPTH          = rrii_pkg::TABLE_DEPTH_DEF;
    localparam int NUM_W          = rrii_pkg::NUM_W;
    localparam int MASK_W         = rrii_pkg::MASK_W;
    localparam int ROUND_W        = rrii_pkg::ROUND_W;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int POOL_SIZE      = 12;

    // action code the block does not define
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    typedef struct {
        logic [2:0]         status;
        logic               fired;
        logic [NUM_W-1:0]   fired_number;
        logic [ROUND_W-1:0] rounds;
    } outcome_t;

    logic                clk        = 1'b0;
    logic                rst_n      = 1'b0;
    logic                start      = 1'b0;
    logic [1:0]          action     = rrii_pkg::ACT_ENABLE;
    logic [NUM_W-1:0]    irq_number = '0;
    logic                cfg_valid  = 1'b0;
    logic [MASK_W-1:0]   cfg_data   = '0;
    logic                busy;
    logic                cfg_ready;
    logic                done;
    logic [2:0]          status;
    logic                fired;
    logic [NUM_W-1:0]    fired_number;
    logic [ROUND_W-1:0]  rounds;

    // shadow copy of the injector state
    logic [NUM_W-1:0]    tbl_number [DEPTH] = '{default: '0};
    logic                tbl_enabled [DEPTH] = '{default: 1'b0};
    int                  tbl_count = 0;
    int                  rr_pointer = 0;
    logic [ROUND_W-1:0]  round_total = '0;
    logic [MASK_W-1:0]   hang_mask_shadow = '0;

    outcome_t            pending_outcomes [$];
    logic [NUM_W-1:0]    small_pool [POOL_SIZE];

    int error_count   = 0;
    int request_count = 0;
    int result_count  = 0;
    int fired_total   = 0;
    int mask_writes   = 0;
    int quiet_cycles  = 0;
    int gapless_left  = 0;

    round_robin_interrupt_injector_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .action       (action),
        .irq_number   (irq_number),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .done         (done),
        .status       (status),
        .fired        (fired),
        .fired_number (fired_number),
        .rounds       (rounds)
    );

    always #HALF_PERIOD clk = ~clk;

    function automatic int lookup_slot(input logic [NUM_W-1:0] num);
        for (int s = 0; s < tbl_count; s++)
            if (tbl_number[s] == num)
                return s;
        return -1;
    endfunction

    function automatic logic [NUM_W-1:0] random_number();
        return NUM_W'($urandom_range(0, (1 << NUM_W) - 1));
    endfunction

    function automatic outcome_t apply_request(input logic [1:0] act,
                                               input logic [NUM_W-1:0] num);
        outcome_t res;
        int hit;
        int n;
        int idx;
        res.status       = rrii_pkg::STAT_NOTFOUND;
        res.fired        = 1'b0;
        res.fired_number = '0;
        case (act)
            rrii_pkg::ACT_ENABLE:
            begin
                hit = lookup_slot(num);
                if (hit >= 0)
                begin
                    tbl_enabled[hit] = 1'b1;
                    res.status = rrii_pkg::STAT_REENABLED;
                end
                else if (tbl_count >= DEPTH)
                    res.status = rrii_pkg::STAT_FULL;
                else
                begin
                    tbl_number[tbl_count]  = num;
                    tbl_enabled[tbl_count] = 1'b1;
                    tbl_count++;
                    res.status = rrii_pkg::STAT_INSERTED;
                end
            end
            rrii_pkg::ACT_DISABLE:
            begin
                hit = lookup_slot(num);
                if (hit >= 0)
                begin
                    tbl_enabled[hit] = 1'b0;
                    res.status = rrii_pkg::STAT_DISABLED;
                end
            end
            rrii_pkg::ACT_FIRE:
            begin
                n = tbl_count;
                for (int i = 0; i < n && !res.fired; i++)
                begin
                    idx = (rr_pointer % n + i) % n;
                    // a round ends each time the scan passes the last slot
                    if (idx == n - 1)
                        round_total++;
                    if (tbl_enabled[idx] && !(idx < MASK_W && hang_mask_shadow[idx]))
                    begin
                        res.fired        = 1'b1;
                        res.fired_number = tbl_number[idx];
                        res.status       = rrii_pkg::STAT_FIRED;
                        rr_pointer       = (idx + 1) % n;
                    end
                end
                if (!res.fired)
                    round_total++;
                else
                    fired_total++;
            end
            default: ;
        endcase
        res.rounds = round_total;
        return res;
    endfunction

    task automatic idle_gap();
        int r;
        int gap;
        r = $urandom_range(0, 99);
        if (gapless_left > 0)
        begin
            gapless_left--;
            gap = 0;
        end
        else if (r < 5)
        begin
            gapless_left = $urandom_range(8, 30);
            gap = 0;
        end
        else if (r < 45)
            gap = 0;
        else if (r < 85)
            gap = $urandom_range(1, 3);
        else if (r < 96)
            gap = $urandom_range(4, 12);
        else
            gap = $urandom_range(20, 60);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // start stays high on return unless an idle gap is drawn, so back-to-back requests need no extra edge
    task automatic send_request(input logic [1:0] act, input logic [NUM_W-1:0] num);
        start      <= 1'b1;
        action     <= act;
        irq_number <= num;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_outcomes.push_back(apply_request(act, num));
        request_count++;
        idle_gap();
    endtask

    task automatic write_hang_mask(input logic [MASK_W-1:0] value);
        start <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        hang_mask_shadow = value;
        mask_writes++;
        cfg_valid <= 1'b0;
    endtask

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin : check_results
        outcome_t want;
        if (done)
        begin
            if (pending_outcomes.size() == 0)
            begin
                $display("%0t: result with no request outstanding, status %0d",
                         $time, status);
                error_count++;
            end
            else
            begin
                want = pending_outcomes.pop_front();
                check_field("status", 32'(want.status), 32'(status));
                check_field("fired", 32'(want.fired), 32'(fired));
                check_field("fired_number", 32'(want.fired_number), 32'(fired_number));
                check_field("rounds", want.rounds, rounds);
                result_count++;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("round_robin_interrupt_injector_unit test failed");
            $finish;
        end
    end

    task automatic run_random_mix(input int count, input bit use_pool);
        int r;
        logic [1:0] act;
        logic [NUM_W-1:0] num;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 35)
                act = rrii_pkg::ACT_ENABLE;
            else if (r < 58)
                act = rrii_pkg::ACT_DISABLE;
            else if (r < 95)
                act = rrii_pkg::ACT_FIRE;
            else
                act = ACT_UNUSED;
            if (use_pool)
                num = small_pool[$urandom_range(0, POOL_SIZE - 1)];
            else if (tbl_count > 0
                     && $urandom_range(0, 99) < (act == rrii_pkg::ACT_DISABLE ? 70 : 50))
                num = tbl_number[$urandom_range(0, tbl_count - 1)];
            else
                num = random_number();
            send_request(act, num);
        end
    endtask

    task automatic test_empty_table();
        send_request(rrii_pkg::ACT_FIRE, '0);
        send_request(rrii_pkg::ACT_DISABLE, 9'h1FF);
        send_request(ACT_UNUSED, 9'h1FF);
    endtask

    task automatic test_insert_and_lookup();
        send_request(rrii_pkg::ACT_ENABLE, 9'h000);
        send_request(rrii_pkg::ACT_ENABLE, 9'h1FF);
        send_request(rrii_pkg::ACT_ENABLE, 9'h0AA);
        send_request(rrii_pkg::ACT_ENABLE, 9'h1FF);
        send_request(rrii_pkg::ACT_DISABLE, 9'h000);
        send_request(rrii_pkg::ACT_DISABLE, 9'h155);
    endtask

    task automatic test_round_robin_wrap();
        // the disabled first slot is skipped on the way round
        repeat (3) send_request(rrii_pkg::ACT_FIRE, 9'h155);
        send_request(rrii_pkg::ACT_ENABLE, 9'h000);
        repeat (3) send_request(rrii_pkg::ACT_FIRE, 9'h0AA);
    endtask

    task automatic test_hang_mask();
        write_hang_mask(32'hFFFF_FFFF);
        send_request(rrii_pkg::ACT_FIRE, '0);
        write_hang_mask(32'h0000_0002);
        repeat (2) send_request(rrii_pkg::ACT_FIRE, '0);
        write_hang_mask(32'h0000_0000);
    endtask

    task automatic test_random_small_table();
        foreach (small_pool[k])
            small_pool[k] = random_number();
        small_pool[0] = 9'h000;
        small_pool[1] = 9'h1FF;
        for (int chunk = 0; chunk < 4; chunk++)
        begin
            write_hang_mask($urandom & $urandom & $urandom);
            run_random_mix(50, 1'b1);
        end
    endtask

    task automatic test_random_growing_table();
        for (int chunk = 0; chunk < 3; chunk++)
        begin
            write_hang_mask(chunk == 2 ? $urandom : ($urandom & $urandom));
            run_random_mix(50, 1'b0);
        end
    endtask

    task automatic test_table_full();
        logic [NUM_W-1:0] num;
        write_hang_mask(32'h0000_0000);
        while (tbl_count < DEPTH)
        begin
            do num = random_number(); while (lookup_slot(num) >= 0);
            send_request(rrii_pkg::ACT_ENABLE, num);
        end
        do num = random_number(); while (lookup_slot(num) >= 0);
        send_request(rrii_pkg::ACT_ENABLE, num);
        send_request(rrii_pkg::ACT_ENABLE, tbl_number[DEPTH - 1]);
        send_request(rrii_pkg::ACT_DISABLE, tbl_number[DEPTH - 1]);
        send_request(rrii_pkg::ACT_ENABLE, tbl_number[DEPTH - 1]);
        write_hang_mask(32'h8000_0000);
        repeat (4) send_request(rrii_pkg::ACT_FIRE, random_number());
        // only the last slot is left eligible
        write_hang_mask(32'h7FFF_FFFF);
        repeat (3) send_request(rrii_pkg::ACT_FIRE, random_number());
    endtask

    task automatic test_random_full_table();
        logic [MASK_W-1:0] mask;
        for (int chunk = 0; chunk < 5; chunk++)
        begin
            case (chunk)
                0: mask = $urandom;
                1: mask = $urandom & $urandom;
                2: mask = 32'hFFFF_FFFF;
                3: mask = $urandom | $urandom;
                default: mask = 32'h0000_0000;
            endcase
            write_hang_mask(mask);
            run_random_mix(35, 1'b0);
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_table();
        test_insert_and_lookup();
        test_round_robin_wrap();
        test_hang_mask();
        test_random_small_table();
        test_random_growing_table();
        test_table_full();
        test_random_full_table();
        start <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("covered %0d requests, %0d of them firing, %0d results checked",
                 request_count, fired_total, result_count);
        $display("hang mask rewritten %0d times, final table size %0d", mask_writes, tbl_count);
        if (error_count == 0)
            $display("round_robin_interrupt_injector_unit test passed");
        else
            $display("round_robin_interrupt_injector_unit test failed");
        $finish;
    end

endmodule
